// ===== hdl/frenet_segment_error_defines.svh =====
// assertion macros for the frenet segment error block
`ifndef FRENET_SEGMENT_ERROR_DEFINES_SVH
`define FRENET_SEGMENT_ERROR_DEFINES_SVH
`ifndef SYNTHESIS
`define FSE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define FSE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FSE_ASSERT_IMP(lbl, ante, cons, msg)
`define FSE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/fse_pkg.sv =====
// constants, types and angle helpers for the frenet segment error block
package fse_pkg;

  localparam int AngW = 24;
  localparam int CorW = 34;

  localparam logic signed [AngW-1:0] PI_Q      = 24'sd205887;
  localparam logic signed [AngW-1:0] TWO_PI_Q  = 24'sd411775;
  localparam logic signed [AngW-1:0] HALF_PI_Q = 24'sd102944;
  localparam logic signed [CorW-1:0] CORDIC_GAIN = 34'sd652032875;

  // geometry carried alongside the divider
  typedef struct packed {
    logic signed [32:0]     abx;
    logic signed [32:0]     aby;
    logic signed [32:0]     apx;
    logic signed [32:0]     apy;
    logic signed [AngW-1:0] ph;
    logic signed [AngW-1:0] h0;
    logic signed [AngW-1:0] dh;
  } geo_t;

  // error terms carried alongside the cordic
  typedef struct packed {
    logic signed [34:0] dx;
    logic signed [34:0] dy;
    logic signed [18:0] epsi;
    logic               flip;
  } err_t;

  function automatic logic signed [AngW-1:0] wrap_ang(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] r;
    r = a;
    for (int k = 0; k < 3; k++) begin
      if (r > PI_Q) r = r - TWO_PI_Q;
    end
    for (int k = 0; k < 3; k++) begin
      if (r < -PI_Q) r = r + TWO_PI_Q;
    end
    return r;
  endfunction

  // arctangent of 2^-i in q30
  function automatic logic signed [CorW-1:0] atan_q30(input logic [4:0] i);
    logic signed [CorW-1:0] v;
    case (i)
      5'd0:  v = 34'sd843314857;
      5'd1:  v = 34'sd497837829;
      5'd2:  v = 34'sd263043837;
      5'd3:  v = 34'sd133525159;
      5'd4:  v = 34'sd67021687;
      5'd5:  v = 34'sd33543516;
      5'd6:  v = 34'sd16775851;
      5'd7:  v = 34'sd8388437;
      5'd8:  v = 34'sd4194283;
      5'd9:  v = 34'sd2097149;
      5'd31: v = 34'sd0;
      default: v = 34'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/frenet_segment_error.sv =====
// top level: pose to segment projection with lateral and heading error
//
//  channel  dir  handshake                     payload
//  s_axis   in   s_axis_tvalid / s_axis_tready pose, segment end points, end headings
//  m_axis   out  m_axis_tvalid / m_axis_tready lateral error, heading error
//
// one word per cycle while the output is not stalled; the projection fraction comes from a
// one-bit-per-stage divider, followed by the cordic stages.
// reset clears only the valid bits, nothing is in flight afterwards.
// a stalled output freezes every stage, nothing is dropped or repeated.
`include "frenet_segment_error_defines.svh"
module frenet_segment_error #(
  parameter int FRAC_BITS    = 16,
  parameter int CORDIC_STEPS = 20
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // pose_x, pose_y, pose_heading, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
  // start_heading, end_heading, zero pad
  input  logic [255:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lateral_error, heading_error, zero pad
  output logic [55:0]  m_axis_tdata
);

  localparam int F    = FRAC_BITS;
  localparam int N    = CORDIC_STEPS;
  localparam int AW   = fse_pkg::AngW;
  localparam int CW   = fse_pkg::CorW;
  localparam int TW   = F + 2;
  localparam int OXW  = TW + 33;
  localparam int OHW  = TW + AW;
  localparam int PW   = 32 + 35;

  localparam logic signed [TW-1:0]  T_ONE  = TW'(1) << F;
  localparam logic signed [OXW-1:0] HALF_X = OXW'(1) << (F - 1);
  localparam logic signed [OHW-1:0] HALF_H = OHW'(1) << (F - 1);

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: differences and heading step
  logic v1_q;
  fse_pkg::geo_t g1_q, g1_d;
  always_comb begin
    g1_d.abx = 33'(signed'(s_axis_tdata[179:148])) - 33'(signed'(s_axis_tdata[115:84]));
    g1_d.aby = 33'(signed'(s_axis_tdata[211:180])) - 33'(signed'(s_axis_tdata[147:116]));
    g1_d.apx = 33'(signed'(s_axis_tdata[31:0]))    - 33'(signed'(s_axis_tdata[115:84]));
    g1_d.apy = 33'(signed'(s_axis_tdata[63:32]))   - 33'(signed'(s_axis_tdata[147:116]));
    g1_d.ph  = AW'(signed'(s_axis_tdata[83:64]));
    g1_d.h0  = AW'(signed'(s_axis_tdata[231:212]));
    g1_d.dh  = fse_pkg::wrap_ang(AW'(signed'(s_axis_tdata[251:232])) - g1_d.h0);
  end

  // stage 2: products
  logic v2_q;
  fse_pkg::geo_t g2_q;
  logic signed [65:0] pp1_q, pp2_q, ll1_q, ll2_q;

  // stage 3: dot product and squared length
  logic v3_q;
  fse_pkg::geo_t g3_q;
  logic signed [66:0] dot_q;
  logic [65:0] len2_q;

  // divider, stage 0 holds the classified operands
  logic          dvld_q [F+1];
  fse_pkg::geo_t dgeo_q [F+1];
  logic [66:0]   drem_q [F+1];
  logic [65:0]   dlen_q [F+1];
  logic [F-1:0]  dquo_q [F+1];
  logic          dfix_q [F+1];
  logic          done_q [F+1];
  logic [66:0]   drem_d [F+1];
  logic [F-1:0]  dquo_d [F+1];

  logic cls_pos, cls_ge;
  always_comb begin
    cls_pos = dot_q > 67'sd0;
    cls_ge  = $unsigned(dot_q) >= {1'b0, len2_q};
    drem_d[0] = (cls_pos && !cls_ge) ? $unsigned(dot_q) : 67'd0;
    dquo_d[0] = '0;
    for (int k = 0; k < F; k++) begin
      logic [66:0] r2;
      r2 = {drem_q[k][65:0], 1'b0};
      if (r2 >= {1'b0, dlen_q[k]}) begin
        drem_d[k+1] = r2 - {1'b0, dlen_q[k]};
        dquo_d[k+1] = {dquo_q[k][F-2:0], 1'b1};
      end else begin
        drem_d[k+1] = r2;
        dquo_d[k+1] = {dquo_q[k][F-2:0], 1'b0};
      end
    end
  end

  logic signed [TW-1:0] t_d;
  always_comb begin
    if (dfix_q[F]) t_d = done_q[F] ? T_ONE : '0;
    else           t_d = {2'b00, dquo_q[F]};
  end

  // stage m: scale by t
  logic vm_q;
  fse_pkg::geo_t gm_q;
  logic signed [OXW-1:0] ox_q, oy_q;
  logic signed [OHW-1:0] oh_q;

  // stage r: rounded offsets and path heading
  logic vr_q;
  logic signed [34:0] dxr_q, dyr_q;
  logic signed [AW-1:0] ph_r_q, wpsi_q;
  logic signed [OXW-1:0] oxr, oyr;
  logic signed [OHW-1:0] ohr;
  always_comb begin
    oxr = (ox_q + HALF_X) >>> F;
    oyr = (oy_q + HALF_X) >>> F;
    ohr = (oh_q + HALF_H) >>> F;
  end

  // stage w: wraps and quadrant fold, feeds cordic stage 0
  logic signed [AW-1:0] wr_a, fold_a, epsi_d;
  logic flip_d;
  always_comb begin
    epsi_d = fse_pkg::wrap_ang(ph_r_q - wpsi_q);
    wr_a   = fse_pkg::wrap_ang(wpsi_q);
    flip_d = 1'b0;
    fold_a = wr_a;
    if (wr_a > fse_pkg::HALF_PI_Q) begin
      fold_a = wr_a - fse_pkg::PI_Q;
      flip_d = 1'b1;
    end else if (wr_a < -fse_pkg::HALF_PI_Q) begin
      fold_a = wr_a + fse_pkg::PI_Q;
      flip_d = 1'b1;
    end
  end

  logic                 cvld_q [N+1];
  fse_pkg::err_t        cerr_q [N+1];
  logic signed [CW-1:0] cx_q [N+1];
  logic signed [CW-1:0] cy_q [N+1];
  logic signed [CW-1:0] cz_q [N+1];
  logic signed [CW-1:0] cx_d [N+1];
  logic signed [CW-1:0] cy_d [N+1];
  logic signed [CW-1:0] cz_d [N+1];

  always_comb begin
    cx_d[0] = fse_pkg::CORDIC_GAIN;
    cy_d[0] = '0;
    cz_d[0] = CW'(fold_a) <<< 14;
    for (int k = 0; k < N; k++) begin
      logic signed [CW-1:0] at;
      at = (k < 32) ? fse_pkg::atan_q30(5'(k)) : '0;
      if (cz_q[k] >= 0) begin
        cx_d[k+1] = cx_q[k] - (cy_q[k] >>> k);
        cy_d[k+1] = cy_q[k] + (cx_q[k] >>> k);
        cz_d[k+1] = cz_q[k] - at;
      end else begin
        cx_d[k+1] = cx_q[k] + (cy_q[k] >>> k);
        cy_d[k+1] = cy_q[k] - (cx_q[k] >>> k);
        cz_d[k+1] = cz_q[k] + at;
      end
    end
  end

  // stage c: cos and sin in q28
  logic vc_q;
  fse_pkg::err_t ec_q;
  logic signed [31:0] cos_q, sin_q;
  logic signed [CW-1:0] xr, yr;
  always_comb begin
    xr = (cx_q[N] + CW'(2)) >>> 2;
    yr = (cy_q[N] + CW'(2)) >>> 2;
    if (cerr_q[N].flip) begin
      xr = -xr;
      yr = -yr;
    end
  end

  // stage p: rotation products
  logic vp_q;
  logic signed [18:0] epsi_p_q;
  logic signed [PW-1:0] pc_q, ps_q;

  // stage o: sum, round, saturate
  logic signed [PW:0] lsum, lsh;
  logic signed [31:0] lat_d;
  always_comb begin
    lsum = (PW+1)'(pc_q) - (PW+1)'(ps_q) + ((PW+1)'(1) <<< 27);
    lsh  = lsum >>> 28;
    if (lsh > (PW+1)'(32'sh7fffffff))       lat_d = 32'sh7fffffff;
    else if (lsh < -((PW+1)'(1) <<< 31))    lat_d = 32'sh80000000;
    else                                    lat_d = lsh[31:0];
  end

  logic signed [31:0] lat_q;
  logic signed [18:0] he_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vm_q <= 1'b0;
      vr_q <= 1'b0;
      vc_q <= 1'b0;
      vp_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int k = 0; k <= F; k++) dvld_q[k] <= 1'b0;
      for (int k = 0; k <= N; k++) cvld_q[k] <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      dvld_q[0] <= v3_q;
      for (int k = 0; k < F; k++) dvld_q[k+1] <= dvld_q[k];
      vm_q <= dvld_q[F];
      vr_q <= vm_q;
      cvld_q[0] <= vr_q;
      for (int k = 0; k < N; k++) cvld_q[k+1] <= cvld_q[k];
      vc_q <= cvld_q[N];
      vp_q <= vc_q;
      out_vld_q <= vp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g1_q  <= g1_d;
      g2_q  <= g1_q;
      pp1_q <= g1_q.apx * g1_q.abx;
      pp2_q <= g1_q.apy * g1_q.aby;
      ll1_q <= g1_q.abx * g1_q.abx;
      ll2_q <= g1_q.aby * g1_q.aby;
      g3_q  <= g2_q;
      dot_q <= 67'(pp1_q) + 67'(pp2_q);
      len2_q <= $unsigned(ll1_q) + $unsigned(ll2_q);
      dgeo_q[0] <= g3_q;
      drem_q[0] <= drem_d[0];
      dlen_q[0] <= len2_q;
      dquo_q[0] <= dquo_d[0];
      dfix_q[0] <= !cls_pos || cls_ge;
      done_q[0] <= cls_pos && cls_ge;
      for (int k = 0; k < F; k++) begin
        dgeo_q[k+1] <= dgeo_q[k];
        drem_q[k+1] <= drem_d[k+1];
        dlen_q[k+1] <= dlen_q[k];
        dquo_q[k+1] <= dquo_d[k+1];
        dfix_q[k+1] <= dfix_q[k];
        done_q[k+1] <= done_q[k];
      end
      gm_q <= dgeo_q[F];
      ox_q <= OXW'(t_d) * OXW'(dgeo_q[F].abx);
      oy_q <= OXW'(t_d) * OXW'(dgeo_q[F].aby);
      oh_q <= OHW'(t_d) * OHW'(dgeo_q[F].dh);
      dxr_q  <= 35'(gm_q.apx) - oxr[34:0];
      dyr_q  <= 35'(gm_q.apy) - oyr[34:0];
      ph_r_q <= gm_q.ph;
      wpsi_q <= gm_q.h0 + ohr[AW-1:0];
      cerr_q[0].dx   <= dxr_q;
      cerr_q[0].dy   <= dyr_q;
      cerr_q[0].epsi <= epsi_d[18:0];
      cerr_q[0].flip <= flip_d;
      for (int k = 0; k <= N; k++) begin
        cx_q[k] <= cx_d[k];
        cy_q[k] <= cy_d[k];
        cz_q[k] <= cz_d[k];
      end
      for (int k = 0; k < N; k++) cerr_q[k+1] <= cerr_q[k];
      ec_q  <= cerr_q[N];
      cos_q <= xr[31:0];
      sin_q <= yr[31:0];
      epsi_p_q <= ec_q.epsi;
      pc_q <= PW'(cos_q) * PW'(ec_q.dy);
      ps_q <= PW'(sin_q) * PW'(ec_q.dx);
      lat_q <= lat_d;
      he_q  <= epsi_p_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {5'd0, he_q, lat_q};

  `FSE_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, v1_q, "accepted word not in stage 1")
  `FSE_ASSERT_IMP(a_t_range, dvld_q[F], (t_d >= 0) && (t_d <= T_ONE), "projection fraction out of range")
  `FSE_ASSERT_IMP(a_he_range, out_vld_q, (he_q >= -19'sd205887) && (he_q <= 19'sd205887), "heading error not wrapped")

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the frenet segment error block: predicted lateral and heading errors
`timescale 1ns / 1ps
module tb_top;

  localparam int FracBits = 16;
  localparam int CordicSteps = 20;
  localparam int Latency = FracBits + CordicSteps + 10;
  localparam int IdleLimit = 4000;
  localparam longint HdgMax = 411775;

  typedef struct {
    logic signed [31:0] px, py, ax, ay, bx, by;
    logic signed [19:0] ph, h0, h1;
  } pose_seg_t;

  class frenet_scoreboard;
    logic [50:0] pending[$];
    int errors = 0;
    longint atan_tab[32] = '{
      843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
      16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
      128, 64, 32, 16, 8, 4, 2, 1, 0};

    function automatic longint wrap_a(longint a);
      while (a > longint'(fse_pkg::PI_Q)) a -= longint'(fse_pkg::TWO_PI_Q);
      while (a < -longint'(fse_pkg::PI_Q)) a += longint'(fse_pkg::TWO_PI_Q);
      return a;
    endfunction

    function automatic longint round_sh(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // accepted input word: work out its errors
    function void note_pose(logic [255:0] d);
      longint px, py, ph, ax, ay, bx, by, h0, h1, abx, aby, apx, apy, t;
      longint dx, dy, wpsi, epsi, w, x, y, z, xs, ys;
      logic signed [127:0] dot, len2, ey;
      bit flip;
      px = longint'($signed(d[31:0]));    py = longint'($signed(d[63:32]));
      ph = longint'($signed(d[83:64]));
      ax = longint'($signed(d[115:84]));  ay = longint'($signed(d[147:116]));
      bx = longint'($signed(d[179:148])); by = longint'($signed(d[211:180]));
      h0 = longint'($signed(d[231:212])); h1 = longint'($signed(d[251:232]));
      abx = bx - ax; aby = by - ay; apx = px - ax; apy = py - ay;
      dot = apx * abx + apy * aby;
      len2 = abx * abx + aby * aby;
      if (dot <= 0) t = 0;
      else if (dot >= len2) t = longint'(1) <<< FracBits;
      else t = longint'((dot <<< FracBits) / len2);
      dx = apx - round_sh(t * abx, FracBits);
      dy = apy - round_sh(t * aby, FracBits);
      wpsi = h0 + round_sh(t * wrap_a(h1 - h0), FracBits);
      epsi = wrap_a(ph - wpsi);
      w = wrap_a(wpsi);
      flip = 0;
      if (w > longint'(fse_pkg::HALF_PI_Q)) begin
        w -= longint'(fse_pkg::PI_Q); flip = 1;
      end else if (w < -longint'(fse_pkg::HALF_PI_Q)) begin
        w += longint'(fse_pkg::PI_Q); flip = 1;
      end
      x = longint'(fse_pkg::CORDIC_GAIN); y = 0; z = w * 16384;
      for (int i = 0; i < CordicSteps && i < 32; i++) begin
        xs = y >>> i; ys = x >>> i;
        if (z >= 0) begin
          x -= xs; y += ys; z -= atan_tab[i];
        end else begin
          x += xs; y -= ys; z += atan_tab[i];
        end
      end
      x = round_sh(x, 2); y = round_sh(y, 2);
      if (flip) begin
        x = -x; y = -y;
      end
      ey = x * dy - y * dx;
      ey = (ey + (128'sd1 <<< 27)) >>> 28;
      if (ey > 128'sd2147483647) ey = 128'sd2147483647;
      if (ey < -128'sd2147483648) ey = -128'sd2147483648;
      pending.push_back({epsi[18:0], ey[31:0]});
    endfunction

    function void check_result(logic [55:0] d);
      logic [50:0] e;
      if (pending.size() == 0) begin
        $error("result word with nothing expected: %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[31:0] !== e[31:0]) begin
        $error("lateral_error expected %0d actual %0d", $signed(e[31:0]), $signed(d[31:0]));
        errors++;
      end
      if (d[50:32] !== e[50:32]) begin
        $error("heading_error expected %0d actual %0d",
               $signed(e[50:32]), $signed(d[50:32]));
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [255:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [55:0] m_axis_tdata;

  frenet_scoreboard sb = new();
  int idle_cycles = 0;
  bit no_idle = 0;

  always begin
    #6 clk_i = 1;
    #6 clk_i = 0;
  end

  frenet_segment_error #(.FRAC_BITS(FracBits), .CORDIC_STEPS(CordicSteps)) DUT (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) sb.note_pose(s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    int g;
    @(posedge rst_ni);
    forever begin
      g = pick_gap();
      @(negedge clk_i);
      m_axis_tready <= (g == 0);
      repeat (g) @(negedge clk_i);
      if (g != 0) m_axis_tready <= 1;
    end
  end

  task automatic send_word(pose_seg_t p);
    int g;
    g = pick_gap();
    if (g != 0) begin
      s_axis_tvalid <= 0;
      repeat (g) @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {4'b0, p.h1, p.h0, p.by, p.bx, p.ay, p.ax, p.ph, p.py, p.px};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  function automatic logic signed [19:0] rand_hdg();
    return 20'($signed(longint'($urandom_range(0, 2 * HdgMax)) - HdgMax));
  endfunction

  function automatic logic signed [31:0] near(logic signed [31:0] base, int spread);
    return base + 32'($signed($urandom_range(0, 2 * spread)) - spread);
  endfunction

  initial begin
    pose_seg_t p;
    int mode;
    repeat (7) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // corners, degenerate segment, clamped ends, heading wraps, half turn
    p = '{px: 32'sh7fffffff, py: 32'sh80000000, ax: 32'sh80000000, ay: 32'sh7fffffff,
          bx: 32'sh7fffffff, by: 32'sh80000000, ph: 20'sd411775, h0: -20'sd411775,
          h1: 20'sd411775};
    send_word(p);
    p = '{px: 32'sh80000000, py: 32'sh7fffffff, ax: 32'sh7fffffff, ay: 32'sh80000000,
          bx: 32'sh80000000, by: 32'sh7fffffff, ph: -20'sd411775, h0: 20'sd411775,
          h1: -20'sd411775};
    send_word(p);
    p = '{px: 32'sh00010000, py: 32'sh00020000, ax: 32'sh00050000, ay: 32'sh00050000,
          bx: 32'sh00050000, by: 32'sh00050000, ph: 20'sd1000, h0: 20'sd205887,
          h1: -20'sd205887};
    send_word(p);
    p = '{px: -32'sh00030000, py: 32'sh00010000, ax: 0, ay: 0, bx: 32'sh000a0000,
          by: 0, ph: 0, h0: 0, h1: 20'sd205887};
    send_word(p);
    p = '{px: 32'sh00200000, py: -32'sh00010000, ax: 0, ay: 0, bx: 32'sh000a0000,
          by: 0, ph: 20'sd102944, h0: 0, h1: 20'sd205887};
    send_word(p);
    p = '{px: 32'sh00050000, py: 32'sh00010000, ax: 0, ay: 0, bx: 32'sh000a0000,
          by: 32'sh000a0000, ph: -20'sd205887, h0: -20'sd102944, h1: 20'sd102944};
    send_word(p);
    p = '{px: 0, py: 0, ax: 0, ay: 0, bx: 0, by: 0, ph: 0, h0: 0, h1: 0};
    send_word(p);
    p = '{px: 32'sh12345678, py: -32'sh0abcdef0, ax: 32'sh00000001, ay: 0,
          bx: 32'sh00000002, by: 0, ph: 20'sd300000, h0: 20'sd205887,
          h1: 20'sd205888};
    send_word(p);
    p = '{px: 32'sh00018000, py: 32'sh00008000, ax: 0, ay: 0, bx: 32'sh00010000,
          by: 32'sh00010000, ph: 20'sd411775, h0: -20'sd300000, h1: 20'sd400000};
    send_word(p);

    for (int n = 0; n < 1500; n++) begin
      if (n % 250 == 0) no_idle = ($urandom_range(0, 3) == 0);
      mode = $urandom_range(0, 9);
      p.ph = rand_hdg(); p.h0 = rand_hdg(); p.h1 = rand_hdg();
      if (mode < 2) begin
        p.px = $urandom(); p.py = $urandom(); p.ax = $urandom(); p.ay = $urandom();
        p.bx = $urandom(); p.by = $urandom();
      end else begin
        p.ax = $urandom();
        p.ay = $urandom();
        p.ax = p.ax >>> $urandom_range(0, 16);
        p.ay = p.ay >>> $urandom_range(0, 16);
        p.bx = near(p.ax, 1 << $urandom_range(4, 24));
        p.by = near(p.ay, 1 << $urandom_range(4, 24));
        if (mode == 2) begin
          p.bx = p.ax; p.by = p.ay;
        end
        p.px = near(p.ax, 1 << $urandom_range(4, 25));
        p.py = near(p.ay, 1 << $urandom_range(4, 25));
      end
      send_word(p);
    end
    s_axis_tvalid <= 0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (Latency + 20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
